// ===== rtl/dacs_pkg.sv =====
// shared types, constants and helpers for the decimal accumulator machine
package dacs_pkg;

    localparam int MEM_DEPTH_DEF = 100;

    localparam int FUNC_W     = 2;
    localparam int ADDR_W     = 7;
    localparam int VAL_W      = 32;
    localparam int WORD_W     = 15;
    localparam int FIELD_W    = 8;
    localparam int STEP_W     = 13;
    localparam int TRY_W      = 3;
    localparam int STATUS_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [ADDR_W-1:0] MSIZE_RST   = 7'd50;
    localparam logic [STEP_W-1:0] MAXSTEP_RST = 13'd5000;
    localparam logic [TRY_W-1:0]  MAXTRY_RST  = 3'd5;

    localparam logic signed [VAL_W-1:0] W_MIN = -32'sd9999;
    localparam logic signed [VAL_W-1:0] W_MAX = 32'sd9999;

    // reciprocal of 100 for splitting a word into opcode and operand
    localparam int RECIP       = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_W     = 14;
    localparam int PROD_W      = 27;
    localparam int QUOT_W      = 7;

    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_MEM_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIES = 2'd2;

    typedef enum logic [FUNC_W-1:0] {
        FN_LOAD,
        FN_RDWORD,
        FN_START,
        FN_STEP
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_HALT,
        ST_RETRY,
        ST_RANGE,
        ST_ADDR,
        ST_OPC,
        ST_STEPS,
        ST_TRIES,
        ST_DIV0
    } stat_code_t;

    localparam logic signed [FIELD_W-1:0] OP_READ   = 8'sd10;
    localparam logic signed [FIELD_W-1:0] OP_WRITE  = 8'sd11;
    localparam logic signed [FIELD_W-1:0] OP_LOAD   = 8'sd20;
    localparam logic signed [FIELD_W-1:0] OP_STORE  = 8'sd21;
    localparam logic signed [FIELD_W-1:0] OP_LOADI  = 8'sd22;
    localparam logic signed [FIELD_W-1:0] OP_STOREI = 8'sd23;
    localparam logic signed [FIELD_W-1:0] OP_ADD    = 8'sd30;
    localparam logic signed [FIELD_W-1:0] OP_SUB    = 8'sd31;
    localparam logic signed [FIELD_W-1:0] OP_DIV    = 8'sd32;
    localparam logic signed [FIELD_W-1:0] OP_MUL    = 8'sd33;
    localparam logic signed [FIELD_W-1:0] OP_JMP    = 8'sd40;
    localparam logic signed [FIELD_W-1:0] OP_JNEG   = 8'sd41;
    localparam logic signed [FIELD_W-1:0] OP_JZERO  = 8'sd42;
    localparam logic signed [FIELD_W-1:0] OP_JNZ    = 8'sd43;
    localparam logic signed [FIELD_W-1:0] OP_LOOP   = 8'sd44;
    localparam logic signed [FIELD_W-1:0] OP_HALT   = 8'sd45;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RDWORD,
        S_FETCH,
        S_OPERAND,
        S_EXEC,
        S_IND,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic latch;
        logic dispatch;
        logic rdword;
        logic fetch;
        logic operand;
        logic exec;
        logic ind;
        logic div_take;
        logic deliver;
    } cmd_t;

    typedef struct packed {
        logic go_read;
        logic go_fetch;
        logic opd_ok;
        logic need_ind;
        logic need_div;
        logic div_done;
        logic out_free;
    } sts_t;

    function automatic logic in_range(input logic signed [VAL_W-1:0] v);
        return (v >= W_MIN) && (v <= W_MAX);
    endfunction

endpackage

// ===== rtl/dacs_if.sv =====
// item channels: command items in, result items out
interface dacs_in_if;
    import dacs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [ADDR_W-1:0]        address;
    logic signed [VAL_W-1:0]  value;
    logic                     value_present;

    modport source (output valid, func, address, value, value_present, input ready);
    modport sink   (input valid, func, address, value, value_present, output ready);
endinterface

interface dacs_out_if;
    import dacs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic [ADDR_W-1:0]         pc_value;
    logic signed [VAL_W-1:0]   accumulator_value;
    logic signed [WORD_W-1:0]  instruction_word;
    logic signed [FIELD_W-1:0] opcode_field;
    logic signed [FIELD_W-1:0] operand_field;
    logic                      print_valid;
    logic signed [WORD_W-1:0]  print_value;
    logic signed [WORD_W-1:0]  read_word;

    modport source (output valid, status, pc_value, accumulator_value,
                    instruction_word, opcode_field, operand_field, print_valid,
                    print_value, read_word, input ready);
    modport sink   (input valid, status, pc_value, accumulator_value,
                    instruction_word, opcode_field, operand_field, print_valid,
                    print_value, read_word, output ready);
endinterface

// ===== rtl/dacs_div.sv =====
// iterative signed divider, one quotient bit per cycle
module dacs_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [dacs_pkg::VAL_W-1:0]   dividend,
    input  logic signed [dacs_pkg::WORD_W-1:0]  divisor,
    output logic                                done,
    output logic signed [dacs_pkg::VAL_W-1:0]   quotient
);
    import dacs_pkg::*;

    logic [VAL_W-1:0]     quo_reg;
    logic [WORD_W-1:0]    rem_reg;
    logic [WORD_W-1:0]    dvs_reg;
    logic                 neg_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;

    logic [WORD_W:0]      trial;
    logic [WORD_W+1:0]    diff;

    assign trial = {rem_reg, quo_reg[VAL_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend[VAL_W-1] ? VAL_W'(-dividend) : VAL_W'(dividend);
            rem_reg <= '0;
            dvs_reg <= divisor[WORD_W-1] ? WORD_W'(-divisor) : WORD_W'(divisor);
            neg_reg <= dividend[VAL_W-1] ^ divisor[WORD_W-1];
        end
        else if (busy_reg)
        begin
            if (!diff[WORD_W+1])
            begin
                rem_reg <= diff[WORD_W-1:0];
                quo_reg <= {quo_reg[VAL_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[WORD_W-1:0];
                quo_reg <= {quo_reg[VAL_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? VAL_W'(-quo_reg) : quo_reg;
endmodule

// ===== rtl/dacs_ctrl.sv =====
// sequencer for one item: dispatch, word read or fetch/operand/exec/ind/div
module dacs_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  dacs_pkg::sts_t sts,
    output dacs_pkg::cmd_t cmd
);
    import dacs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (sts.go_read)
                begin
                    state_next = S_RDWORD;
                end
                else if (sts.go_fetch)
                begin
                    state_next = S_FETCH;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RDWORD:  state_next = S_DONE;
            S_FETCH:   state_next = S_OPERAND;
            S_OPERAND: state_next = sts.opd_ok ? S_EXEC : S_DONE;
            S_EXEC:
            begin
                if (sts.need_ind)
                begin
                    state_next = S_IND;
                end
                else if (sts.need_div)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_IND:     state_next = S_DONE;
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
            end
            S_DISPATCH: cmd.dispatch = 1'b1;
            S_RDWORD:   cmd.rdword   = 1'b1;
            S_FETCH:    cmd.fetch    = 1'b1;
            S_OPERAND:  cmd.operand  = 1'b1;
            S_EXEC:     cmd.exec     = 1'b1;
            S_IND:      cmd.ind      = 1'b1;
            S_DIV:      cmd.div_take = sts.div_done;
            S_DONE:     cmd.deliver  = sts.out_free;
            default:    cmd          = '0;
        endcase
    end
endmodule

// ===== rtl/dacs_dp.sv =====
// datapath: word memory, machine registers, execute logic and result register
module dacs_dp #(
    parameter int MEM_DEPTH = dacs_pkg::MEM_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [dacs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dacs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [dacs_pkg::FUNC_W-1:0]          in_func,
    input  logic [dacs_pkg::ADDR_W-1:0]          in_address,
    input  logic signed [dacs_pkg::VAL_W-1:0]    in_value,
    input  logic                                 in_value_present,
    input  dacs_pkg::cmd_t                       cmd,
    output dacs_pkg::sts_t                       sts,
    dacs_out_if.source                           rsp
);
    import dacs_pkg::*;

    localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // configuration
    logic [ADDR_W-1:0] msize_reg;
    logic [STEP_W-1:0] maxstep_reg;
    logic [TRY_W-1:0]  maxtry_reg;

    // latched item
    func_t                   func_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic                    pres_reg;

    // machine state
    logic signed [VAL_W-1:0] acc_reg;
    logic [ADDR_W-1:0]       pc_reg;
    logic [STEP_W-1:0]       steps_reg;
    logic [TRY_W-1:0]        tries_reg;
    stat_code_t              run_reg;

    // per item result
    stat_code_t                stat_reg;
    logic signed [WORD_W-1:0]  iw_reg;
    logic signed [FIELD_W-1:0] opc_reg;
    logic signed [FIELD_W-1:0] opd_reg;
    logic                      pv_reg;
    logic signed [WORD_W-1:0]  pval_reg;
    logic signed [WORD_W-1:0]  rword_reg;

    // output register
    logic                      ov_reg;
    stat_code_t                o_stat_reg;
    logic [ADDR_W-1:0]         o_pc_reg;
    logic signed [VAL_W-1:0]   o_acc_reg;
    logic signed [WORD_W-1:0]  o_iw_reg;
    logic signed [FIELD_W-1:0] o_opc_reg;
    logic signed [FIELD_W-1:0] o_opd_reg;
    logic                      o_pv_reg;
    logic signed [WORD_W-1:0]  o_pval_reg;
    logic signed [WORD_W-1:0]  o_rword_reg;

    // word memory
    logic [WORD_W-1:0]    mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] vld_reg;
    logic [WORD_W-1:0]    rdata_reg;
    logic                 rvld_reg;

    logic [ADDR_W-1:0]        size;
    logic signed [WORD_W-1:0] rd;
    logic signed [VAL_W-1:0]  m32;
    logic                     m_ok;
    logic                     opd_ok;
    logic                     addr_ok;
    logic                     go_fetch;
    stat_code_t               disp_st;

    logic [WORD_W-1:0]         mag;
    logic [PROD_W-1:0]         qprod;
    logic [QUOT_W-1:0]         q;
    logic [RECIP_W-1:0]        qx100;
    logic [QUOT_W-1:0]         r;
    logic signed [FIELD_W-1:0] spl_opc;
    logic signed [FIELD_W-1:0] spl_opd;

    stat_code_t              x_st;
    logic                    x_acc_we;
    logic signed [VAL_W-1:0] x_acc;
    logic [ADDR_W-1:0]       x_npc;
    logic [TRY_W-1:0]        x_tries;
    logic [TRY_W-1:0]        tries_inc;
    logic                    x_pv;
    logic                    x_wr;
    logic [ADDR_W-1:0]       x_wa;
    logic [WORD_W-1:0]       x_wd;
    logic                    x_ind;
    logic                    x_div;
    logic signed [VAL_W-1:0] acc_dec;
    logic signed [VAL_W-1:0] prod;

    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_wa;
    logic [WORD_W-1:0]       mem_wd;
    logic                    rd_en;
    logic [ADDR_W-1:0]       raddr;

    logic                    div_done;
    logic signed [VAL_W-1:0] div_q;

    assign size = (msize_reg < ADDR_W'(MEM_DEPTH)) ? msize_reg : ADDR_W'(MEM_DEPTH);
    assign rd   = rvld_reg ? rdata_reg : '0;
    assign m32  = VAL_W'(rd);
    assign m_ok = !rd[WORD_W-1] && (rd[WORD_W-2:0] < (WORD_W-1)'(size));

    assign opd_ok   = !opd_reg[FIELD_W-1] && (opd_reg[ADDR_W-1:0] < size);
    assign addr_ok  = addr_reg < size;
    assign go_fetch = (func_reg == FN_STEP) && (run_reg == ST_OK)
                      && (steps_reg < maxstep_reg) && (pc_reg < size);

    // opcode and operand split of the fetched word
    assign mag     = rd[WORD_W-1] ? WORD_W'(-rd) : WORD_W'(rd);
    assign qprod   = PROD_W'(mag[RECIP_W-1:0]) * PROD_W'(RECIP);
    assign q       = qprod[RECIP_SHIFT +: QUOT_W];
    assign qx100   = RECIP_W'(q) * RECIP_W'(100);
    assign r       = QUOT_W'(mag[RECIP_W-1:0] - qx100);
    assign spl_opc = rd[WORD_W-1] ? -FIELD_W'(q) : FIELD_W'(q);
    assign spl_opd = rd[WORD_W-1] ? -FIELD_W'(r) : FIELD_W'(r);

    always_comb
    begin
        unique case (func_reg)
            FN_LOAD:
            begin
                if (!addr_ok)
                begin
                    disp_st = ST_ADDR;
                end
                else if (!in_range(val_reg))
                begin
                    disp_st = ST_RANGE;
                end
                else
                begin
                    disp_st = ST_OK;
                end
            end
            FN_RDWORD: disp_st = addr_ok ? ST_OK : ST_ADDR;
            FN_START:  disp_st = ST_OK;
            FN_STEP:
            begin
                if (run_reg != ST_OK)
                begin
                    disp_st = run_reg;
                end
                else if (steps_reg >= maxstep_reg)
                begin
                    disp_st = ST_STEPS;
                end
                else if (pc_reg >= size)
                begin
                    disp_st = ST_ADDR;
                end
                else
                begin
                    disp_st = ST_OK;
                end
            end
            default:   disp_st = ST_OK;
        endcase
    end

    assign acc_dec   = acc_reg - 32'sd1;
    assign prod      = acc_reg * m32;
    assign tries_inc = tries_reg + 1'b1;

    always_comb
    begin
        x_st     = ST_OK;
        x_acc_we = 1'b0;
        x_acc    = acc_reg;
        x_npc    = pc_reg + 1'b1;
        x_tries  = tries_reg;
        x_pv     = 1'b0;
        x_wr     = 1'b0;
        x_wa     = opd_reg[ADDR_W-1:0];
        x_wd     = val_reg[WORD_W-1:0];
        x_ind    = 1'b0;
        x_div    = 1'b0;
        unique case (opc_reg)
            OP_READ:
            begin
                if (pres_reg && in_range(val_reg))
                begin
                    x_wr    = 1'b1;
                    x_tries = '0;
                end
                else
                begin
                    x_tries = tries_inc;
                    x_st    = (tries_inc >= maxtry_reg) ? ST_TRIES : ST_RETRY;
                end
            end
            OP_WRITE: x_pv = 1'b1;
            OP_LOAD:
            begin
                x_acc_we = 1'b1;
                x_acc    = m32;
            end
            OP_STORE:
            begin
                if (!in_range(acc_reg))
                begin
                    x_st = ST_RANGE;
                end
                else
                begin
                    x_wr = 1'b1;
                    x_wd = acc_reg[WORD_W-1:0];
                end
            end
            OP_LOADI:
            begin
                if (!m_ok)
                begin
                    x_st = ST_ADDR;
                end
                else
                begin
                    x_ind = 1'b1;
                end
            end
            OP_STOREI:
            begin
                if (!m_ok)
                begin
                    x_st = ST_ADDR;
                end
                else if (!in_range(acc_reg))
                begin
                    x_st = ST_RANGE;
                end
                else
                begin
                    x_wr = 1'b1;
                    x_wa = rd[ADDR_W-1:0];
                    x_wd = acc_reg[WORD_W-1:0];
                end
            end
            OP_ADD:
            begin
                x_acc_we = 1'b1;
                x_acc    = acc_reg + m32;
            end
            OP_SUB:
            begin
                x_acc_we = 1'b1;
                x_acc    = acc_reg - m32;
            end
            OP_DIV:
            begin
                if (rd == '0)
                begin
                    x_st = ST_DIV0;
                end
                else
                begin
                    x_div = 1'b1;
                end
            end
            OP_MUL:
            begin
                x_acc_we = 1'b1;
                x_acc    = prod;
            end
            OP_JMP:   x_npc = opd_reg[ADDR_W-1:0];
            OP_JNEG:
            begin
                if (acc_reg < 0)
                begin
                    x_npc = opd_reg[ADDR_W-1:0];
                end
            end
            OP_JZERO:
            begin
                if (acc_reg == '0)
                begin
                    x_npc = opd_reg[ADDR_W-1:0];
                end
            end
            OP_JNZ:
            begin
                if (acc_reg != '0)
                begin
                    x_npc = opd_reg[ADDR_W-1:0];
                end
            end
            OP_LOOP:
            begin
                x_acc_we = 1'b1;
                x_acc    = acc_dec;
                if (acc_dec != '0)
                begin
                    x_npc = opd_reg[ADDR_W-1:0];
                end
            end
            OP_HALT:  x_st = ST_HALT;
            default:  x_st = ST_OPC;
        endcase
    end

    // memory port selection
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = addr_reg;
        mem_wd = val_reg[WORD_W-1:0];
        if (cmd.dispatch && (func_reg == FN_LOAD) && (disp_st == ST_OK))
        begin
            mem_we = 1'b1;
        end
        else if (cmd.exec && x_wr)
        begin
            mem_we = 1'b1;
            mem_wa = x_wa;
            mem_wd = x_wd;
        end
    end

    always_comb
    begin
        rd_en = 1'b0;
        raddr = addr_reg;
        if (cmd.dispatch && (func_reg == FN_RDWORD) && addr_ok)
        begin
            rd_en = 1'b1;
        end
        else if (cmd.dispatch && go_fetch)
        begin
            rd_en = 1'b1;
            raddr = pc_reg;
        end
        else if (cmd.operand && opd_ok)
        begin
            rd_en = 1'b1;
            raddr = opd_reg[ADDR_W-1:0];
        end
        else if (cmd.exec && x_ind)
        begin
            rd_en = 1'b1;
            raddr = rd[ADDR_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa[AW-1:0]] <= mem_wd;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr[AW-1:0]];
        end
    end

    // unwritten words read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                vld_reg[mem_wa[AW-1:0]] <= 1'b1;
            end
            if (rd_en)
            begin
                rvld_reg <= vld_reg[raddr[AW-1:0]];
            end
        end
    end

    dacs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.exec && x_div),
        .dividend (acc_reg),
        .divisor  (rd),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            func_reg <= func_t'(in_func);
            addr_reg <= in_address;
            val_reg  <= in_value;
            pres_reg <= in_value_present;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msize_reg   <= MSIZE_RST;
            maxstep_reg <= MAXSTEP_RST;
            maxtry_reg  <= MAXTRY_RST;
            acc_reg     <= '0;
            pc_reg      <= '0;
            steps_reg   <= '0;
            tries_reg   <= '0;
            run_reg     <= ST_OK;
            stat_reg    <= ST_OK;
            iw_reg      <= '0;
            opc_reg     <= '0;
            opd_reg     <= '0;
            pv_reg      <= 1'b0;
            pval_reg    <= '0;
            rword_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MEM_SIZE:  msize_reg   <= cfg_data[ADDR_W-1:0];
                    CFG_MAX_STEPS: maxstep_reg <= cfg_data[STEP_W-1:0];
                    CFG_MAX_TRIES: maxtry_reg  <= cfg_data[TRY_W-1:0];
                    default:       msize_reg   <= msize_reg;
                endcase
            end
            if (cmd.dispatch)
            begin
                stat_reg  <= disp_st;
                iw_reg    <= '0;
                opc_reg   <= '0;
                opd_reg   <= '0;
                pv_reg    <= 1'b0;
                pval_reg  <= '0;
                rword_reg <= '0;
                if (func_reg == FN_START)
                begin
                    acc_reg   <= '0;
                    pc_reg    <= '0;
                    steps_reg <= '0;
                    tries_reg <= '0;
                    run_reg   <= ST_OK;
                end
                if ((func_reg == FN_STEP) && (disp_st != ST_OK))
                begin
                    run_reg <= disp_st;
                end
            end
            if (cmd.rdword)
            begin
                rword_reg <= rd;
            end
            if (cmd.fetch)
            begin
                iw_reg  <= rd;
                opc_reg <= spl_opc;
                opd_reg <= spl_opd;
            end
            if (cmd.operand && !opd_ok)
            begin
                stat_reg <= ST_ADDR;
                run_reg  <= ST_ADDR;
            end
            if (cmd.exec)
            begin
                stat_reg  <= x_st;
                tries_reg <= x_tries;
                pv_reg    <= x_pv;
                pval_reg  <= x_pv ? rd : '0;
                if (x_acc_we)
                begin
                    acc_reg <= x_acc;
                end
                if (x_st == ST_OK)
                begin
                    pc_reg    <= x_npc;
                    steps_reg <= steps_reg + 1'b1;
                end
                else if (x_st == ST_HALT)
                begin
                    steps_reg <= steps_reg + 1'b1;
                end
                if ((x_st != ST_OK) && (x_st != ST_RETRY))
                begin
                    run_reg <= x_st;
                end
            end
            if (cmd.ind)
            begin
                acc_reg <= m32;
            end
            if (cmd.div_take)
            begin
                acc_reg <= div_q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (cmd.deliver)
        begin
            ov_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.deliver)
        begin
            o_stat_reg  <= stat_reg;
            o_pc_reg    <= pc_reg;
            o_acc_reg   <= acc_reg;
            o_iw_reg    <= iw_reg;
            o_opc_reg   <= opc_reg;
            o_opd_reg   <= opd_reg;
            o_pv_reg    <= pv_reg;
            o_pval_reg  <= pval_reg;
            o_rword_reg <= rword_reg;
        end
    end

    assign rsp.valid             = ov_reg;
    assign rsp.status            = o_stat_reg;
    assign rsp.pc_value          = o_pc_reg;
    assign rsp.accumulator_value = o_acc_reg;
    assign rsp.instruction_word  = o_iw_reg;
    assign rsp.opcode_field      = o_opc_reg;
    assign rsp.operand_field     = o_opd_reg;
    assign rsp.print_valid       = o_pv_reg;
    assign rsp.print_value       = o_pval_reg;
    assign rsp.read_word         = o_rword_reg;

    assign sts.go_read  = (func_reg == FN_RDWORD) && addr_ok;
    assign sts.go_fetch = go_fetch;
    assign sts.opd_ok   = opd_ok;
    assign sts.need_ind = x_ind;
    assign sts.need_div = x_div;
    assign sts.div_done = div_done;
    assign sts.out_free = !ov_reg || rsp.ready;
endmodule

// ===== rtl/decimal_accumulator_cpu_step.sv =====
// one item at a time; load and start items need only dispatch, a word read adds a memory read,
// an instruction step goes through fetch, operand and execute, then an indirect read or divide
// the memory read port serves fetch, operand, indirect and word reads; writes use a second port
// a new item is taken while the previous result still waits in the output register
// reset is asynchronous: machine state clears, memory reads zero, registers go to 50, 5000, 5
module decimal_accumulator_cpu_step #(
    parameter int MEM_DEPTH = dacs_pkg::MEM_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    dacs_in_if.sink                         req,
    dacs_out_if.source                      rsp,
    input  logic                            cfg_we,
    input  logic [dacs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dacs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dacs_pkg::*;

    cmd_t cmd;
    sts_t sts;

    dacs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dacs_dp #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_func          (req.func),
        .in_address       (req.address),
        .in_value         (req.value),
        .in_value_present (req.value_present),
        .cmd              (cmd),
        .sts              (sts),
        .rsp              (rsp)
    );
endmodule

// ===== rtl/dacs_checker.sv =====
// port level checks for the decimal accumulator machine, bound to the top level
module dacs_sva_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [dacs_pkg::STATUS_W-1:0]       out_status,
    input logic                                out_print_valid,
    input logic signed [dacs_pkg::FIELD_W-1:0] out_opcode
);
    import dacs_pkg::*;

    // one item in flight: no accept right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("item accepted while previous item in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped before taken");

    a_print_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_print_valid) |-> (out_status == ST_OK))
        else $error("print with non-ok status");

    a_retry_read: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_status == ST_RETRY)) |-> (out_opcode == OP_READ))
        else $error("read retry on an instruction other than read");
endmodule

bind decimal_accumulator_cpu_step dacs_sva_checker u_dacs_sva_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (req.valid),
    .in_ready        (req.ready),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_status      (rsp.status),
    .out_print_valid (rsp.print_valid),
    .out_opcode      (rsp.opcode_field)
);

// ===== dv/dacs_checker.sv =====
// result checker: watches both channels, runs the machine model and compares each result item
module dacs_checker
    import dacs_pkg::*;
#(
    parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    dacs_in_if                    req,
    dacs_out_if                   rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);
    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [ADDR_W-1:0]         pc;
        logic [VAL_W-1:0]          acc;
        logic [WORD_W-1:0]         iw;
        logic [FIELD_W-1:0]        opc;
        logic [FIELD_W-1:0]        opd;
        logic                      pvalid;
        logic [WORD_W-1:0]         pval;
        logic [WORD_W-1:0]         rword;
    } machine_result_t;

    machine_result_t expected_q[$];
    int         mem[MEM_DEPTH];
    int         acc;
    int         pc;
    int         steps_done;
    int         tries;
    stat_code_t run_st;
    int         msize;
    int         max_steps;
    int         max_tries;

    function automatic bit word_ok(longint v);
        return v >= -9999 && v <= 9999;
    endfunction

    function automatic machine_result_t machine_step(logic [FUNC_W-1:0] fn, int addr,
                                                     int val, bit present);
        machine_result_t r;
        longint size, a, m, iw, opc, opd;
        stat_code_t st;
        int npc;
        size = (msize < MEM_DEPTH) ? msize : MEM_DEPTH;
        st = ST_OK;
        r = '0;
        iw = 0; opc = 0; opd = 0;
        if (fn == FN_LOAD) begin
            if (addr >= size) st = ST_ADDR;
            else if (!word_ok(val)) st = ST_RANGE;
            else mem[addr] = val;
        end else if (fn == FN_RDWORD) begin
            if (addr >= size) st = ST_ADDR;
            else r.rword = WORD_W'(mem[addr]);
        end else if (fn == FN_START) begin
            pc = 0; acc = 0; steps_done = 0; tries = 0; run_st = ST_OK;
        end else if (run_st != ST_OK) begin
            st = run_st;
        end else if (steps_done >= max_steps) begin
            st = ST_STEPS;
        end else if (pc >= size) begin
            st = ST_ADDR;
        end else begin
            a = acc;
            npc = pc + 1;
            iw = mem[pc];
            opc = iw / 100;
            opd = iw % 100;
            if (opd < 0 || opd >= size) st = ST_ADDR;
            else begin
                m = mem[opd];
                case (opc)
                    OP_READ:
                        if (present && word_ok(val)) begin
                            mem[opd] = val; tries = 0;
                        end else begin
                            tries = (tries + 1) & 7;
                            st = (tries >= max_tries) ? ST_TRIES : ST_RETRY;
                        end
                    OP_WRITE: begin r.pvalid = 1; r.pval = WORD_W'(m); end
                    OP_LOAD: acc = int'(m);
                    OP_STORE: if (!word_ok(a)) st = ST_RANGE; else mem[opd] = int'(a);
                    OP_LOADI: if (m < 0 || m >= size) st = ST_ADDR; else acc = mem[m];
                    OP_STOREI:
                        if (m < 0 || m >= size) st = ST_ADDR;
                        else if (!word_ok(a)) st = ST_RANGE;
                        else mem[m] = int'(a);
                    OP_ADD: acc = int'(a + m);
                    OP_SUB: acc = int'(a - m);
                    OP_DIV: if (m == 0) st = ST_DIV0; else acc = int'(a / m);
                    OP_MUL: acc = int'(a * m);
                    OP_JMP: npc = int'(opd);
                    OP_JNEG: if (a < 0) npc = int'(opd);
                    OP_JZERO: if (a == 0) npc = int'(opd);
                    OP_JNZ: if (a != 0) npc = int'(opd);
                    OP_LOOP: begin
                        acc = int'(a - 1);
                        if (acc != 0) npc = int'(opd);
                    end
                    OP_HALT: st = ST_HALT;
                    default: st = ST_OPC;
                endcase
            end
            if (st == ST_OK) begin
                pc = npc & 127;
                steps_done = (steps_done + 1) & 8191;
            end else if (st == ST_HALT) begin
                steps_done = (steps_done + 1) & 8191;
            end
        end
        if (fn == FN_STEP && st != ST_OK && st != ST_RETRY) run_st = st;
        r.status = st;
        r.pc = pc[ADDR_W-1:0];
        r.acc = acc;
        r.iw = iw[WORD_W-1:0];
        r.opc = opc[FIELD_W-1:0];
        r.opd = opd[FIELD_W-1:0];
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n) begin
        machine_result_t got, want;
        if (!rst_n) begin
            foreach (mem[i]) mem[i] = 0;
            acc = 0; pc = 0; steps_done = 0; tries = 0; run_st = ST_OK;
            msize = 50; max_steps = 5000; max_tries = 5;
            expected_q.delete();
            errors <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MEM_SIZE: msize = cfg_data[ADDR_W-1:0];
                    CFG_MAX_STEPS: max_steps = cfg_data[STEP_W-1:0];
                    CFG_MAX_TRIES: max_tries = cfg_data[TRY_W-1:0];
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready) begin
                got = {rsp.status, rsp.pc_value, rsp.accumulator_value,
                       rsp.instruction_word, rsp.opcode_field, rsp.operand_field,
                       rsp.print_valid, rsp.print_value, rsp.read_word};
                if (expected_q.size() == 0) begin
                    if (errors < 10) $display("unexpected result item %p", got);
                    errors <= errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        if (errors < 10) $display("mismatch: expected %p got %p", want, got);
                        errors <= errors + 1;
                    end
                end
            end
            if (req.valid && req.ready)
                expected_q.push_back(machine_step(req.func, int'(req.address),
                                                  req.value, req.value_present));
        end
    end
endmodule

// ===== dv/tb_decimal_accumulator_cpu_step.sv =====
// testbench top: drives command items, configuration and back-pressure, prints the verdict
module tb_decimal_accumulator_cpu_step;
    import dacs_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int errors, pending;
    int cycles = 0;

    dacs_in_if req ();
    dacs_out_if rsp ();

    decimal_accumulator_cpu_step dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data));

    dacs_checker chk (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .errors(errors), .pending(pending));

    always #5 clk = ~clk;

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial begin
        req.valid = 0; req.func = '0; req.address = '0; req.value = '0;
        req.value_present = 0;
    end

    // receiver stalls
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) rsp.ready <= 0;
        else if (cycles % 2000 < 300) rsp.ready <= 1;
        else rsp.ready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 900000) begin
            $display("FAIL decimal_accumulator_cpu_step");
            $finish;
        end
    end

    // valid stays high after an accept until the next send or drain takes it over
    task automatic send(logic [FUNC_W-1:0] fn, int addr, int val, bit present);
        int g;
        g = (cycles % 3000 < 400) ? 0 : gap_len();
        if (g > 0)
        begin
            req.valid <= 0;
            repeat (g) @(posedge clk);
        end
        req.valid <= 1; req.func <= fn; req.address <= addr[ADDR_W-1:0];
        req.value <= val; req.value_present <= present;
        do @(posedge clk); while (!req.ready);
    endtask

    task automatic drain();
        req.valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= val[CFG_DATA_W-1:0];
        @(posedge clk);
    endtask

    function automatic int rand_word();
        int p;
        p = $urandom_range(0, 9);
        if (p < 7) return $urandom_range(0, 19998) - 9999;
        if (p < 9) return $urandom_range(0, 99);
        return $urandom();
    endfunction

    function automatic int rand_opcode();
        int ops[16] = '{10, 11, 20, 21, 22, 23, 30, 31, 32, 33, 40, 41, 42, 43, 44, 45};
        if ($urandom_range(0, 19) == 0) return $urandom_range(0, 99);
        return ops[$urandom_range(0, 15)];
    endfunction

    // small random program and data words, a start, then a run of steps with random read values and a word read
    task automatic run_program(int size);
        int n, w, sign, k;
        n = $urandom_range(1, size);
        for (k = 0; k < n; k++) begin
            sign = ($urandom_range(0, 15) == 0) ? -1 : 1;
            w = sign * (rand_opcode() * 100 + $urandom_range(0, (size < 100) ? size : 99));
            if (w > 9999) w = 9999;
            if (w < -9999) w = -9999;
            send(FN_LOAD, k, w, 0);
        end
        for (k = 0; k < 3; k++)
            send(FN_LOAD, $urandom_range(0, size - 1), $urandom_range(0, 40) - 20, 0);
        send(FN_START, $urandom_range(0, 127), $urandom(), 1'($urandom_range(0, 1)));
        n = $urandom_range(4, 30);
        for (k = 0; k < n; k++)
            send(FN_STEP, $urandom_range(0, 127), rand_word(), $urandom_range(0, 5) != 0);
        send(FN_RDWORD, $urandom_range(0, size), 0, 0);
    endtask

    initial begin
        int sizes[5] = '{1, 100, 127, 12, 50};
        int ph, k, sz;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: loads at the edges, word reads, a short program of read, add, divide and indirect store, faults
        send(FN_LOAD, 0, 9999, 0);
        send(FN_LOAD, 49, -9999, 0);
        send(FN_LOAD, 50, 1, 0);
        send(FN_LOAD, 127, 1, 0);
        send(FN_LOAD, 1, 10000, 0);
        send(FN_LOAD, 1, 32'h8000_0000, 1);
        send(FN_RDWORD, 49, 0, 0);
        send(FN_RDWORD, 127, 0, 0);
        send(FN_LOAD, 0, 1010, 0);
        send(FN_LOAD, 1, 3010, 0);
        send(FN_LOAD, 2, 3210, 0);
        send(FN_LOAD, 3, 2310, 0);
        send(FN_LOAD, 4, -4510, 0);
        send(FN_START, 0, 0, 0);
        send(FN_STEP, 0, 0, 0);
        send(FN_STEP, 0, 20000, 1);
        send(FN_STEP, 0, 7, 1);
        send(FN_STEP, 0, 0, 0);
        send(FN_STEP, 0, 0, 0);
        send(FN_STEP, 0, 0, 0);
        send(FN_STEP, 0, 0, 0);
        send(FN_STEP, 0, 0, 0);
        // pause until every result is in
        drain();
        for (ph = 0; ph < 10; ph++) begin
            sz = sizes[ph % 5];
            set_reg(CFG_MEM_SIZE, sz);
            set_reg(CFG_MAX_STEPS, (ph % 3 == 0) ? $urandom_range(1, 6) :
                                   (ph % 3 == 1) ? 8191 : $urandom_range(7, 5000));
            set_reg(CFG_MAX_TRIES, (ph % 4 == 0) ? 1 : (ph % 4 == 1) ? 7 :
                                   $urandom_range(0, 7));
            cfg_we <= 0;
            if (sz > 100) sz = 100;
            for (k = 0; k < 3; k++) run_program(sz);
            for (k = 0; k < 6; k++)
                send(FUNC_W'($urandom_range(0, 3)), $urandom_range(0, 127), $urandom(),
                     1'($urandom_range(0, 1)));
            drain();
        end
        drain();
        if (errors == 0) $display("PASS decimal_accumulator_cpu_step");
        else $display("FAIL decimal_accumulator_cpu_step");
        $finish;
    end
endmodule
